// File: hdl/mwpo_pkg.sv
package mwpo_pkg;

  localparam int FreqW      = 24;
  localparam int ScaleW     = 40;
  localparam int DutyW      = 16;
  localparam int SampleW    = 16;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 40;
  localparam int ScaleSplit = 20;
  localparam int FracBits   = 24;
  localparam int RomW       = 15;
  localparam int QueueDepth = 4;

  localparam logic [ScaleW-1:0] ScaleReset = 40'd93824992237;
  localparam logic [DutyW-1:0]  DutyReset  = 16'd32768;

  typedef enum logic [2:0] {
    WaveSine    = 3'd0,
    WaveSquare  = 3'd1,
    WaveSawDown = 3'd2,
    WaveSawUp   = 3'd3,
    WavePwm     = 3'd4
  } wave_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWaveform  = 2'd0,
    CfgFreqScale = 2'd1,
    CfgDuty      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]       waveform;
    logic [DutyW-1:0] duty;
  } back_cfg_t;

  // quarter-wave sine entry m of a table with 2^qbits steps, Taylor series in Q30
  function automatic logic [RomW-1:0] quarter_sine(int unsigned m, int unsigned qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] v;
    x    = (64'(m) * 64'd1686629713) >> qbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    // terms 1..7 divide by (2n)(2n+1), odd terms subtract
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[RomW-1:0];
  endfunction

endpackage

// File: hdl/mwpo_if.sv
interface mwpo_freq_if;
  logic                              valid;
  logic                              ready;
  logic signed [mwpo_pkg::FreqW-1:0] frequency;

  modport source (output valid, output frequency, input ready);
  modport sink   (input valid, input frequency, output ready);
endinterface

interface mwpo_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [mwpo_pkg::SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// File: hdl/mwpo_front.sv
module mwpo_front #(
  parameter int PHASE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mwpo_freq_if.sink                     in,
  input  logic [mwpo_pkg::ScaleW-1:0]   freq_scale_i,
  output logic                          push_o,
  output logic [PHASE_BITS-1:0]         step_o,
  input  logic                          push_ready_i
);

  localparam int HalfW = mwpo_pkg::ScaleW - mwpo_pkg::ScaleSplit;
  localparam int PpW   = mwpo_pkg::FreqW + HalfW + 1;
  localparam int ExtW  = (PHASE_BITS + mwpo_pkg::FracBits > mwpo_pkg::FreqW + mwpo_pkg::ScaleW)
                         ? PHASE_BITS + mwpo_pkg::FracBits
                         : mwpo_pkg::FreqW + mwpo_pkg::ScaleW;

  logic                  v_q;
  logic                  adv;
  logic signed [PpW-1:0] pp_lo_d, pp_hi_d, pp_lo_q, pp_hi_q;
  logic signed [HalfW:0] lo_s, hi_s;
  logic signed [ExtW-1:0] lo_ext, hi_ext, sum;

  assign adv      = !v_q || push_ready_i;
  assign in.ready = adv;

  assign lo_s    = $signed({1'b0, freq_scale_i[mwpo_pkg::ScaleSplit-1:0]});
  assign hi_s    = $signed({1'b0, freq_scale_i[mwpo_pkg::ScaleW-1:mwpo_pkg::ScaleSplit]});
  assign pp_lo_d = PpW'(in.frequency) * PpW'(lo_s);
  assign pp_hi_d = PpW'(in.frequency) * PpW'(hi_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in.valid) begin
      pp_lo_q <= pp_lo_d;
      pp_hi_q <= pp_hi_d;
    end
  end

  // signed product, floor shift by the fraction bits
  assign lo_ext = ExtW'(pp_lo_q);
  assign hi_ext = ExtW'(pp_hi_q);
  assign sum    = lo_ext + (hi_ext <<< mwpo_pkg::ScaleSplit);

  assign push_o = v_q;
  assign step_o = sum[mwpo_pkg::FracBits +: PHASE_BITS];

endmodule

// File: hdl/mwpo_queue.sv
module mwpo_queue #(
  parameter int DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic              wr_ready_o,
  output logic              rd_valid_o,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              rd_pop_i
);

  localparam int PtrW = $clog2(mwpo_pkg::QueueDepth);

  logic [DATA_W-1:0] mem_q [mwpo_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     count_q;
  logic              wr_en, rd_en;

  assign wr_ready_o = count_q != (PtrW + 1)'(mwpo_pkg::QueueDepth);
  assign rd_valid_o = count_q != '0;
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_pop_i && rd_valid_o;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count_q <= count_q + (PtrW + 1)'(1);
        2'b01:   count_q <= count_q - (PtrW + 1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: hdl/mwpo_back.sv
module mwpo_back #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_INDEX_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_valid_i,
  input  logic [PHASE_BITS-1:0] step_i,
  output logic                  pop_o,
  input  mwpo_pkg::back_cfg_t   cfg_i,
  mwpo_sample_if.source         out
);

  localparam int QBits    = SINE_INDEX_BITS - 2;
  localparam int QSize    = 1 << QBits;
  localparam int AddrW    = QBits + 1;
  localparam int SawShift = PHASE_BITS - 16;
  localparam int SW       = mwpo_pkg::SampleW;

  localparam logic [PHASE_BITS-1:0] HalfPhase = {1'b1, {(PHASE_BITS - 1){1'b0}}};
  localparam logic [SW-1:0] PosFull = 16'sd32767;
  localparam logic [SW-1:0] NegFull = -16'sd32767;

  logic [mwpo_pkg::RomW-1:0] rom_w [QSize + 1];

  for (genvar m = 0; m <= QSize; m++) begin : g_rom
    localparam logic [mwpo_pkg::RomW-1:0] Val = mwpo_pkg::quarter_sine(m, QBits);
    assign rom_w[m] = Val;
  end

  logic [PHASE_BITS-1:0]      phase_q;
  logic                       b1_v_q, out_v_q;
  logic                       b1_en, out_en;
  logic [mwpo_pkg::RomW-1:0]  rom_q;
  logic [SW-1:0]              shape_d, shape_q, sample_q, sine_mag;
  logic                       sine_q, neg_q;
  logic [SINE_INDEX_BITS-1:0] idx;
  logic [QBits-1:0]           k;
  logic [AddrW-1:0]           addr;
  logic [15:0]                top;
  logic [PHASE_BITS-1:0]      pwm_thr;

  assign out_en = !out_v_q || out.ready;
  assign b1_en  = !b1_v_q || out_en;
  assign pop_o  = step_valid_i && b1_en;

  assign idx     = phase_q[PHASE_BITS-1 -: SINE_INDEX_BITS];
  assign k       = idx[QBits-1:0];
  assign addr    = idx[QBits] ? (AddrW'(QSize) - {1'b0, k}) : {1'b0, k};
  assign top     = phase_q[PHASE_BITS-1 -: 16];
  assign pwm_thr = PHASE_BITS'(cfg_i.duty) << SawShift;

  always_comb begin
    case (cfg_i.waveform)
      mwpo_pkg::WaveSquare:  shape_d = (phase_q <= HalfPhase) ? PosFull : NegFull;
      mwpo_pkg::WaveSawDown: shape_d = 16'h7FFF - top;
      mwpo_pkg::WaveSawUp:   shape_d = top - 16'h8000;
      mwpo_pkg::WavePwm:     shape_d = (phase_q <= pwm_thr) ? PosFull : NegFull;
      default:               shape_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      b1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_q + step_i;
      end
      if (b1_en) begin
        b1_v_q <= pop_o;
      end
      if (out_en) begin
        out_v_q <= b1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rom_q   <= rom_w[addr];
      shape_q <= shape_d;
      sine_q  <= cfg_i.waveform == mwpo_pkg::WaveSine;
      neg_q   <= idx[QBits + 1];
    end
  end

  assign sine_mag = {1'b0, rom_q};

  always_ff @(posedge clk_i) begin
    if (out_en && b1_v_q) begin
      if (sine_q) begin
        sample_q <= neg_q ? (16'h0000 - sine_mag) : sine_mag;
      end else begin
        sample_q <= shape_q;
      end
    end
  end

  assign out.valid  = out_v_q;
  assign out.sample = $signed(sample_q);

endmodule

// File: hdl/multi_waveform_phase_oscillator.sv
// Channel     Dir  Payload                      Handshake
// freq_i      in   frequency  24-bit signed     valid/ready, item taken when both high
// sample_o    out  sample     16-bit signed     valid/ready, item taken when both high
// cfg_*_i     in   idx 2 bits, data 40 bits     write on cfg_we_i, no back-pressure
//
// One item per cycle sustained while sample_o.ready stays high; a taken frequency reaches sample_o.valid
// through the multiplier stage, step queue, phase/sine-ROM stage and output register, in that order.
// Reset clears the phase to zero and loads the register defaults.
// A stalled output fills the back stages, then the queue, then holds freq_i.ready low.
module multi_waveform_phase_oscillator #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_INDEX_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mwpo_freq_if.sink                       freq_i,
  mwpo_sample_if.source                   sample_o,
  input  logic                            cfg_we_i,
  input  logic [mwpo_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mwpo_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic [2:0]                     waveform_q;
  logic [mwpo_pkg::ScaleW-1:0]    freq_scale_q;
  logic [mwpo_pkg::DutyW-1:0]     duty_q;
  mwpo_pkg::back_cfg_t            back_cfg;

  logic                  push, push_ready;
  logic [PHASE_BITS-1:0] push_step, pop_step;
  logic                  pop_valid, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q   <= mwpo_pkg::WaveSine;
      freq_scale_q <= mwpo_pkg::ScaleReset;
      duty_q       <= mwpo_pkg::DutyReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mwpo_pkg::CfgWaveform:  waveform_q   <= cfg_data_i[2:0];
        mwpo_pkg::CfgFreqScale: freq_scale_q <= cfg_data_i[mwpo_pkg::ScaleW-1:0];
        mwpo_pkg::CfgDuty:      duty_q       <= cfg_data_i[mwpo_pkg::DutyW-1:0];
        default: ;
      endcase
    end
  end

  assign back_cfg.waveform = waveform_q;
  assign back_cfg.duty     = duty_q;

  mwpo_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in           (freq_i),
    .freq_scale_i (freq_scale_q),
    .push_o       (push),
    .step_o       (push_step),
    .push_ready_i (push_ready)
  );

  mwpo_queue #(
    .DATA_W (PHASE_BITS)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push),
    .wr_data_i  (push_step),
    .wr_ready_o (push_ready),
    .rd_valid_o (pop_valid),
    .rd_data_o  (pop_step),
    .rd_pop_i   (pop)
  );

  mwpo_back #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_INDEX_BITS (SINE_INDEX_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (pop_valid),
    .step_i       (pop_step),
    .pop_o        (pop),
    .cfg_i        (back_cfg),
    .out          (sample_o)
  );

endmodule
